/* design/clpc_pkg.sv */
// Package for the circle lattice point counter: widths, limits and state codes.
// Depends on nothing; imported by circle_lattice_point_counter_top.
`timescale 1ns / 1ps

package clpc_pkg;

  // Default width of the squared radius field.
  localparam int RADIUS_SQ_WIDTH_DEF = 31;

  // Width of the point count field.
  localparam int COUNT_WIDTH = 18;

  // Width of the saturating hit counter. Its top bit set means the scaled count overflows.
  localparam int HIT_WIDTH = COUNT_WIDTH - 1;

  // Largest point count the output field can hold.
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

/* design/circle_lattice_point_counter_top.sv */
// Circle lattice point counter: r2(n), the number of integer points on x*x + y*y = n.
// Holds the digit-serial square root, the residual walk and the output register.
// Depends on clpc_pkg.
`timescale 1ns / 1ps

//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------
//  input   | valid        | stall (out)  | r_squared   [RADIUS_SQ_WIDTH]
//  output  | out_valid    | out_stall    | point_count [18]
//
// The square root takes one cycle per two input bits, and the walk then takes
// one cycle per step of either pointer, which is isqrt(n) steps at most (about
// 46300 at 31 bits). The zero radius skips the root and the walk. Reset clears
// the state and the output valid. The input stalls while an item is in work; a
// finished result waits in the output register, and the block only waits in its
// final state if that register is still full and stalled.

module circle_lattice_point_counter_top
  import clpc_pkg::*;
#(
  parameter int RADIUS_SQ_WIDTH = RADIUS_SQ_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  output logic                       stall,
  input  logic [RADIUS_SQ_WIDTH-1:0] r_squared,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COUNT_WIDTH-1:0]     point_count
);

  // Root width, padded radicand width, remainder width, x width and residual width.
  localparam int SW  = (RADIUS_SQ_WIDTH + 1) / 2;
  localparam int NW  = 2 * SW;
  localparam int RW  = SW + 2;
  localparam int XW  = SW + 1;
  localparam int DW  = NW + 2;
  localparam int SCW = $clog2(SW + 1);

  state_t state, state_next;

  // Radicand shift register, two bits leave at the top each root cycle.
  logic [NW-1:0]         nsh, nsh_next;
  logic [SW-1:0]         root, root_next;
  logic [RW-1:0]         rem, rem_next;
  logic [SCW-1:0]        step, step_next;

  // Walk pointers and the residual d = n - x*x - y*y.
  logic [XW-1:0]         x, x_next;
  logic [SW-1:0]         y, y_next;
  logic signed [DW-1:0]  d, d_next;
  logic [HIT_WIDTH-1:0]  hits, hits_next;
  logic                  zero_n, zero_n_next;

  logic                  out_valid_next;
  logic [COUNT_WIDTH-1:0] point_count_next;

  // One restoring square root digit.
  logic [RW+1:0]         rem_sh;
  logic [RW+1:0]         trial;
  logic                  root_ge;
  logic [RW-1:0]         rem_step;
  logic [SW-1:0]         root_step;

  // Walk step terms.
  logic signed [DW-1:0]  y_term;
  logic signed [DW-1:0]  x_term;
  logic [HIT_WIDTH-1:0]  hit_inc;
  logic [COUNT_WIDTH-1:0] result;
  logic                  out_free;

  assign rem_sh    = {rem, nsh[NW-1 -: 2]};
  assign trial     = (RW + 2)'({root, 2'b01});
  assign root_ge   = (rem_sh >= trial);
  assign rem_step  = root_ge ? RW'(rem_sh - trial) : RW'(rem_sh);
  assign root_step = {root[SW-2:0], root_ge};

  // Moving y down by one adds 2y-1; moving x up by one subtracts 2x+1 of the old x.
  assign y_term  = DW'({y, 1'b0}) - DW'(1);
  assign x_term  = DW'({x, 1'b0}) + DW'(1);
  assign hit_inc = (x == XW'(y)) ? HIT_WIDTH'(1) : HIT_WIDTH'(2);

  // The hit counter freezes once its top bit is set, which maps to the saturated count.
  assign result = zero_n ? COUNT_WIDTH'(1)
                : hits[HIT_WIDTH-1] ? COUNT_MAX
                : {hits[HIT_WIDTH-2:0], 2'b00};

  assign out_free = !out_valid || !out_stall;
  assign stall    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    nsh         <= nsh_next;
    root        <= root_next;
    rem         <= rem_next;
    step        <= step_next;
    x           <= x_next;
    y           <= y_next;
    d           <= d_next;
    hits        <= hits_next;
    zero_n      <= zero_n_next;
    point_count <= point_count_next;
  end

  always_comb begin
    state_next       = state;
    nsh_next         = nsh;
    root_next        = root;
    rem_next         = rem;
    step_next        = step;
    x_next           = x;
    y_next           = y;
    d_next           = d;
    hits_next        = hits;
    zero_n_next      = zero_n;
    point_count_next = point_count;
    out_valid_next   = out_valid && out_stall;

    case (state)
      ST_IDLE: begin
        if (valid) begin
          nsh_next    = NW'(r_squared);
          root_next   = '0;
          rem_next    = '0;
          step_next   = SCW'(SW - 1);
          zero_n_next = (r_squared == '0);
          // The zero radius has the single point at the origin and skips all work.
          state_next  = (r_squared == '0) ? ST_FINISH : ST_ROOT;
        end
      end

      ST_ROOT: begin
        nsh_next  = {nsh[NW-3:0], 2'b00};
        root_next = root_step;
        rem_next  = rem_step;
        step_next = step - SCW'(1);
        if (step == '0) begin
          // Start the walk at x = 1, y = isqrt(n); a zero remainder means n is a square.
          x_next     = XW'(1);
          y_next     = root_step;
          d_next     = DW'(rem_step) - DW'(1);
          hits_next  = (rem_step == '0) ? HIT_WIDTH'(1) : '0;
          state_next = ST_WALK;
        end
      end

      ST_WALK: begin
        // Only pairs with x <= y are visited; x < y counts for itself and its mirror.
        if (x > XW'(y)) begin
          state_next = ST_FINISH;
        end else if (d[DW-1]) begin
          d_next = d + y_term;
          y_next = y - SW'(1);
        end else begin
          if ((d == '0) && !hits[HIT_WIDTH-1]) begin
            hits_next = hits + hit_inc;
          end
          d_next = d - x_term;
          x_next = x + XW'(1);
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          point_count_next = result;
          out_valid_next   = 1'b1;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
